// ===== hw/rtl/path_mtu_cache_with_aging_defines.svh =====
// Assertion macros shared by the path MTU cache RTL.
`ifndef PATH_MTU_CACHE_WITH_AGING_DEFINES_SVH
`define PATH_MTU_CACHE_WITH_AGING_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication: whenever ante holds, cons must hold too.
`define PMTU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Next-cycle implication: cons must hold in the cycle after ante.
`define PMTU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define PMTU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PMTU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/pmtu_pkg.sv =====
// Shared types, codes and constants of the path MTU cache.
package pmtu_pkg;

    // Transaction modes on the item channel.
    localparam logic [1:0] MODE_TRANSMIT = 2'd0;
    localparam logic [1:0] MODE_REPORT   = 2'd1;
    localparam logic [1:0] MODE_TICK     = 2'd2;

    // Report outcome codes.
    localparam logic [1:0] STATUS_IGNORED  = 2'd0;
    localparam logic [1:0] STATUS_UPDATED  = 2'd1;
    localparam logic [1:0] STATUS_INSERTED = 2'd2;
    localparam logic [1:0] STATUS_DROPPED  = 2'd3;

    // Configuration register indexes.
    localparam logic [0:0] CFG_SWEEP_PERIOD  = 1'b0;
    localparam logic [0:0] CFG_ENTRY_TIMEOUT = 1'b1;

    localparam logic [31:0] SWEEP_PERIOD_RESET  = 32'd1000;
    localparam logic [31:0] ENTRY_TIMEOUT_RESET = 32'd6000;

    localparam logic [15:0] DF_LIMIT          = 16'd576;
    localparam logic [15:0] IPV4_HDR_LEN      = 16'd20;
    localparam logic [7:0]  ICMP_TYPE_UNREACH = 8'd3;
    localparam logic [7:0]  ICMP_CODE_FRAG    = 8'd4;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] mtu;
        logic [31:0] stamp;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_EVAL,
        ST_SWEEP,
        ST_INSERT,
        ST_DONE
    } pmtu_state_t;

    // XOR fold of the address; the bucket is this value modulo the bucket count.
    function automatic logic [31:0] pmtu_fold(input logic [31:0] a);
        logic [31:0] h;
        h = a ^ (a >> 16);
        return h ^ (h >> 8);
    endfunction

endpackage

// ===== hw/rtl/pmtu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pmtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/pmtu_hash.sv =====
// Bucket hash: XOR fold of the address reduced modulo the bucket count.
module pmtu_hash
    import pmtu_pkg::*;
#(
    parameter int BUCKETS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [31:0]                addr,
    output logic                       done,
    output logic [$clog2(BUCKETS)-1:0] bucket
);

    localparam int BW = $clog2(BUCKETS);
    localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

    logic [31:0] folded;

    assign folded = pmtu_fold(addr);

    generate
        if (IS_POW2)
        begin : g_mask
            // A power-of-two count keeps only the low bits, so the bucket is ready at once.
            assign done   = start;
            assign bucket = folded[BW-1:0];
        end
        else
        begin : g_serial
            // Byte-serial remainder, most significant byte first: r = (r * 256 + byte) mod N.
            logic [BW-1:0] shift_tab [2**BW];
            logic [BW-1:0] byte_tab [256];
            logic [31:0]   h_reg;
            logic [BW-1:0] r_reg;
            logic [BW-1:0] r_next;
            logic [BW:0]   sum;
            logic          busy_reg;
            logic [1:0]    step_reg;
            logic          done_reg;

            for (genvar i = 0; i < 2**BW; i++)
            begin : g_shift
                assign shift_tab[i] = BW'((i * 256) % BUCKETS);
            end
            for (genvar j = 0; j < 256; j++)
            begin : g_byte
                assign byte_tab[j] = BW'(j % BUCKETS);
            end

            always_comb
            begin
                sum = {1'b0, shift_tab[r_reg]} + {1'b0, byte_tab[h_reg[31:24]]};
                if (sum >= (BW + 1)'(BUCKETS))
                begin
                    r_next = BW'(sum - (BW + 1)'(BUCKETS));
                end
                else
                begin
                    r_next = sum[BW-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    step_reg <= 2'd0;
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= busy_reg && (step_reg == 2'd3);
                    if (start)
                    begin
                        busy_reg <= 1'b1;
                        step_reg <= 2'd0;
                    end
                    else if (busy_reg)
                    begin
                        step_reg <= step_reg + 2'd1;
                        if (step_reg == 2'd3)
                        begin
                            busy_reg <= 1'b0;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    h_reg <= folded;
                    r_reg <= '0;
                end
                else if (busy_reg)
                begin
                    h_reg <= {h_reg[23:0], 8'h00};
                    r_reg <= r_next;
                end
            end

            assign done   = done_reg;
            assign bucket = r_reg;
        end
    endgenerate

endmodule

// ===== hw/rtl/path_mtu_cache_with_aging.sv =====
// Top level of the hashed path MTU cache with timeout aging.
//
// Channel  Dir  Handshake                  Fields
// item     in   item_valid / item_stall    mode, dest_addr, icmp_type, icmp_code,
//                                          reported_mtu, route_mtu, payload_len
// result   out  result_valid / result_stall cache_hit, path_mtu, too_big,
//                                          dont_fragment, report_status
// cfg      in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One transaction at a time: accept, then evaluate the bucket row read from RAM, with the
// byte-serial modulo run first when BUCKETS is not a power of two.
// A report that inserts adds an insert step; an aging sweep walks one RAM row per cycle
// over all BUCKETS rows, and an insert follows it when one is pending.
// Reset clears the valid flip-flops at once, so no clearing pass is needed.
// A stalled result waits in the output register while the next transaction is accepted;
// that transaction then holds in its final state until the output register frees.
`include "path_mtu_cache_with_aging_defines.svh"

module path_mtu_cache_with_aging
    import pmtu_pkg::*;
#(
    parameter int BUCKETS = 16,
    parameter int WAYS    = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] dest_addr,
    input  logic [7:0]  icmp_type,
    input  logic [7:0]  icmp_code,
    input  logic [15:0] reported_mtu,
    input  logic [15:0] route_mtu,
    input  logic [15:0] payload_len,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        cache_hit,
    output logic [15:0] path_mtu,
    output logic        too_big,
    output logic        dont_fragment,
    output logic [1:0]  report_status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int BW    = $clog2(BUCKETS);
    localparam int SCW   = $clog2(BUCKETS + 1);
    localparam int ROW_W = WAYS * $bits(entry_t);

    pmtu_state_t state_reg;
    pmtu_state_t state_next;

    logic        item_accept;
    logic        out_free;
    logic        hash_done;
    logic [BW-1:0] hash_bucket;

    logic             ram_we;
    logic             ram_re;
    logic [BW-1:0]    ram_raddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;

    // Item held for the duration of the transaction.
    logic [1:0]  mode_reg;
    logic [31:0] addr_reg;
    logic [7:0]  type_reg;
    logic [7:0]  code_reg;
    logic [15:0] rep_reg;
    logic [15:0] route_reg;
    logic [15:0] plen_reg;
    logic [BW-1:0] bucket_reg;

    logic [WAYS-1:0] valid_reg [BUCKETS];
    logic [31:0] time_reg;
    logic [31:0] last_sweep_reg;
    logic [31:0] period_reg;
    logic [31:0] timeout_reg;
    logic        insert_pend_reg;

    entry_t [WAYS-1:0] row_reg;
    entry_t [WAYS-1:0] rd_row;
    entry_t [WAYS-1:0] upd_row;
    entry_t [WAYS-1:0] ins_row;

    logic [SCW-1:0] sweep_cnt_reg;
    logic           chk_valid_reg;
    logic [BW-1:0]  chk_row_reg;
    logic           sweep_end;

    logic [WAYS-1:0] bucket_valid;
    logic [WAYS-1:0] hit_vec;
    logic [WAYS-1:0] hit_sel;
    logic [WAYS-1:0] free_sel;
    logic [WAYS-1:0] stale_vec;
    logic            any_hit;
    logic            any_free;
    logic            report_act;
    logic            do_lookup;
    logic            sweep_due;
    logic [15:0]     hit_mtu;
    logic [15:0]     rep_mtu;
    logic [15:0]     xmit_mtu;
    logic            xmit_df;

    logic        eval_hit;
    logic [15:0] eval_mtu;
    logic        eval_big;
    logic        eval_df;
    logic [1:0]  eval_status;
    logic        eval_load;
    logic        done_load;

    logic        res_hit_reg;
    logic [15:0] res_mtu_reg;
    logic        res_big_reg;
    logic        res_df_reg;
    logic [1:0]  res_status_reg;

    logic        result_valid_reg;
    logic        out_hit_reg;
    logic [15:0] out_mtu_reg;
    logic        out_big_reg;
    logic        out_df_reg;
    logic [1:0]  out_status_reg;

    pmtu_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (item_accept),
        .addr   (dest_addr),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    // One row per bucket holds all of its ways, so a probe is a single read.
    pmtu_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (bucket_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign item_accept = item_valid && !item_stall;
    assign out_free    = !result_valid_reg || !result_stall;
    assign cfg_ready   = 1'b1;
    assign rd_row      = ram_rdata;
    assign sweep_end   = (state_reg == ST_SWEEP) && (sweep_cnt_reg == SCW'(BUCKETS));

    assign report_act  = (mode_reg == MODE_REPORT) && (type_reg == ICMP_TYPE_UNREACH)
                         && (code_reg == ICMP_CODE_FRAG);
    assign do_lookup   = (mode_reg == MODE_TRANSMIT) || report_act;
    assign sweep_due   = (time_reg - last_sweep_reg) > period_reg;
    assign rep_mtu     = (rep_reg >= IPV4_HDR_LEN) ? (rep_reg - IPV4_HDR_LEN) : 16'd0;

    always_comb
    begin
        bucket_valid = valid_reg[bucket_reg];
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w]   = bucket_valid[w] && (rd_row[w].addr == addr_reg);
            stale_vec[w] = (time_reg - rd_row[w].stamp) > timeout_reg;
        end
        // Lowest set bit of the hit vector and lowest clear bit of the valid vector.
        hit_sel  = hit_vec & (~hit_vec + WAYS'(1));
        free_sel = ~bucket_valid & (bucket_valid + WAYS'(1));
        any_hit  = |hit_vec;
        any_free = ~&bucket_valid;

        hit_mtu = 16'd0;
        upd_row = rd_row;
        ins_row = row_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (hit_sel[w])
            begin
                hit_mtu           = rd_row[w].mtu;
                upd_row[w].stamp  = time_reg;
                if (report_act)
                begin
                    upd_row[w].mtu = rep_mtu;
                end
            end
            if (free_sel[w])
            begin
                ins_row[w].addr  = addr_reg;
                ins_row[w].mtu   = rep_mtu;
                ins_row[w].stamp = time_reg;
            end
        end

        xmit_mtu = any_hit ? hit_mtu : route_reg;
        xmit_df  = xmit_mtu > DF_LIMIT;

        eval_hit    = 1'b0;
        eval_mtu    = 16'd0;
        eval_big    = 1'b0;
        eval_df     = 1'b0;
        eval_status = STATUS_IGNORED;
        case (mode_reg)
            MODE_TRANSMIT:
            begin
                eval_hit = any_hit;
                eval_mtu = xmit_mtu;
                eval_df  = xmit_df;
                eval_big = xmit_df && (plen_reg > xmit_mtu);
            end
            MODE_REPORT:
            begin
                if (report_act)
                begin
                    eval_hit    = any_hit;
                    eval_mtu    = rep_mtu;
                    // A miss is settled by the insert step after any sweep.
                    eval_status = any_hit ? STATUS_UPDATED : STATUS_DROPPED;
                end
            end
            default:
            begin
                eval_hit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    state_next = hash_done ? ST_EVAL : ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (do_lookup && sweep_due)
                begin
                    state_next = ST_SWEEP;
                end
                else if (report_act && !any_hit)
                begin
                    state_next = ST_INSERT;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SWEEP:
            begin
                if (sweep_end)
                begin
                    state_next = insert_pend_reg ? ST_INSERT : ST_DONE;
                end
            end
            ST_INSERT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall = 1'b1;
        ram_re     = 1'b0;
        ram_raddr  = hash_bucket;
        ram_we     = 1'b0;
        ram_wdata  = upd_row;
        eval_load  = 1'b0;
        done_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                ram_re     = item_accept && hash_done;
            end
            ST_HASH:
            begin
                ram_re = hash_done;
            end
            ST_EVAL:
            begin
                // The hit refresh is written before any sweep reads the row back.
                ram_we    = do_lookup && any_hit;
                eval_load = !(do_lookup && sweep_due) && !(report_act && !any_hit) && out_free;
            end
            ST_SWEEP:
            begin
                ram_re    = sweep_cnt_reg < SCW'(BUCKETS);
                ram_raddr = sweep_cnt_reg[BW-1:0];
            end
            ST_INSERT:
            begin
                ram_we    = any_free;
                ram_wdata = ins_row;
            end
            ST_DONE:
            begin
                done_load = out_free;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            time_reg         <= 32'd0;
            last_sweep_reg   <= 32'd0;
            period_reg       <= SWEEP_PERIOD_RESET;
            timeout_reg      <= ENTRY_TIMEOUT_RESET;
            insert_pend_reg  <= 1'b0;
            sweep_cnt_reg    <= '0;
            chk_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            valid_reg        <= '{default: '0};
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= (state_reg == ST_SWEEP) && ram_re;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SWEEP_PERIOD:  period_reg  <= cfg_data;
                    CFG_ENTRY_TIMEOUT: timeout_reg <= cfg_data;
                    default:           period_reg  <= period_reg;
                endcase
            end

            if (state_reg == ST_EVAL)
            begin
                insert_pend_reg <= report_act && !any_hit;
                sweep_cnt_reg   <= '0;
                if (mode_reg == MODE_TICK)
                begin
                    time_reg <= time_reg + 32'd1;
                end
                if (do_lookup && sweep_due)
                begin
                    last_sweep_reg <= time_reg;
                end
            end
            else if ((state_reg == ST_SWEEP) && ram_re)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + SCW'(1);
            end

            // Each swept row arrives in the cycle after its read was issued.
            if (chk_valid_reg)
            begin
                valid_reg[chk_row_reg] <= valid_reg[chk_row_reg] & ~stale_vec;
            end
            if (state_reg == ST_INSERT)
            begin
                valid_reg[bucket_reg] <= bucket_valid | free_sel;
            end

            if (eval_load || done_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            mode_reg  <= mode;
            addr_reg  <= dest_addr;
            type_reg  <= icmp_type;
            code_reg  <= icmp_code;
            rep_reg   <= reported_mtu;
            route_reg <= route_mtu;
            plen_reg  <= payload_len;
        end
        if (ram_re && (state_reg != ST_SWEEP))
        begin
            bucket_reg <= hash_bucket;
        end
        chk_row_reg <= sweep_cnt_reg[BW-1:0];

        if (state_reg == ST_EVAL)
        begin
            row_reg        <= rd_row;
            res_hit_reg    <= eval_hit;
            res_mtu_reg    <= eval_mtu;
            res_big_reg    <= eval_big;
            res_df_reg     <= eval_df;
            res_status_reg <= eval_status;
        end
        else if (state_reg == ST_INSERT)
        begin
            res_status_reg <= any_free ? STATUS_INSERTED : STATUS_DROPPED;
        end

        if (eval_load)
        begin
            out_hit_reg    <= eval_hit;
            out_mtu_reg    <= eval_mtu;
            out_big_reg    <= eval_big;
            out_df_reg     <= eval_df;
            out_status_reg <= eval_status;
        end
        else if (done_load)
        begin
            out_hit_reg    <= res_hit_reg;
            out_mtu_reg    <= res_mtu_reg;
            out_big_reg    <= res_big_reg;
            out_df_reg     <= res_df_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign cache_hit     = out_hit_reg;
    assign path_mtu      = out_mtu_reg;
    assign too_big       = out_big_reg;
    assign dont_fragment = out_df_reg;
    assign report_status = out_status_reg;

    // The sweep must run against the time at which it was started.
    `PMTU_ASSERT_IMP(a_sweep_stamp, clk, rst_n, state_reg == ST_SWEEP, last_sweep_reg == time_reg)
    // Inserts happen only on a miss, so a bucket never holds the same address twice.
    `PMTU_ASSERT_IMP(a_single_hit, clk, rst_n, state_reg == ST_EVAL, $onehot0(hit_vec))
    // The sweep only clears valid bits; the row memory must stay untouched.
    `PMTU_ASSERT_IMP(a_sweep_no_write, clk, rst_n, state_reg == ST_SWEEP, !ram_we)
    // A tick transaction advances the clock by exactly one.
    `PMTU_ASSERT_NEXT(a_tick_step, clk, rst_n, state_reg == ST_EVAL && mode_reg == MODE_TICK, time_reg == $past(time_reg) + 32'd1)

endmodule

// ===== tb/sv/tb_path_mtu_cache_with_aging.sv =====
// Self-checking testbench for the path MTU cache: directed table, then random phases.
`timescale 1ns / 1ps

module tb_path_mtu_cache_with_aging;
    import pmtu_pkg::*;

    localparam int BUCKET_COUNT = 16;
    localparam int WAY_COUNT    = 4;
    localparam int SLOT_COUNT   = BUCKET_COUNT * WAY_COUNT;
    localparam int POOL_SIZE    = 24;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 326;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 40;
    localparam int STALL_LIMIT  = 5000;
    localparam logic [1:0] MODE_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] dest_addr;
        logic [7:0]  icmp_type;
        logic [7:0]  icmp_code;
        logic [15:0] reported_mtu;
        logic [15:0] route_mtu;
        logic [15:0] payload_len;
    } txn_t;

    typedef struct packed {
        logic        cache_hit;
        logic [15:0] path_mtu;
        logic        too_big;
        logic        dont_fragment;
        logic [1:0]  report_status;
    } mtu_result_t;

    typedef struct packed {
        txn_t        txn;
        logic        known;
        mtu_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [1:0]  mode = MODE_TICK;
    logic [31:0] dest_addr = '0;
    logic [7:0]  icmp_type = '0;
    logic [7:0]  icmp_code = '0;
    logic [15:0] reported_mtu = '0;
    logic [15:0] route_mtu = '0;
    logic [15:0] payload_len = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        cache_hit;
    logic [15:0] path_mtu;
    logic        too_big;
    logic        dont_fragment;
    logic [1:0]  report_status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = CFG_SWEEP_PERIOD;
    logic [31:0] cfg_data = '0;

    // Shadow copy of the cache used for prediction.
    logic        ent_valid [SLOT_COUNT];
    logic [31:0] ent_addr  [SLOT_COUNT];
    logic [15:0] ent_mtu   [SLOT_COUNT];
    logic [31:0] ent_stamp [SLOT_COUNT];
    logic [31:0] now_ticks;
    logic [31:0] last_sweep;
    logic [31:0] sweep_period;
    logic [31:0] entry_timeout;

    mtu_result_t pending_results [$];
    stim_row_t   directed_rows [$];
    logic [31:0] addr_pool [POOL_SIZE];
    logic [31:0] phase_period  [PHASES] = '{32'd0, 32'hFFFF_FFFF, 32'd4, 32'd25, 32'd1};
    logic [31:0] phase_timeout [PHASES] = '{32'd0, 32'hFFFF_FFFF, 32'd30, 32'd12, 32'd60};

    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;
    bit hold_pending = 1'b0;

    path_mtu_cache_with_aging #(
        .BUCKETS(BUCKET_COUNT),
        .WAYS(WAY_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .mode(mode),
        .dest_addr(dest_addr),
        .icmp_type(icmp_type),
        .icmp_code(icmp_code),
        .reported_mtu(reported_mtu),
        .route_mtu(route_mtu),
        .payload_len(payload_len),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .cache_hit(cache_hit),
        .path_mtu(path_mtu),
        .too_big(too_big),
        .dont_fragment(dont_fragment),
        .report_status(report_status),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // With 16 buckets only the low nibble of the fold matters, which is the XOR of four nibbles.
    function automatic int bucket_index(input logic [31:0] a);
        logic [3:0] nib;
        begin
            nib = a[3:0] ^ a[11:8] ^ a[19:16] ^ a[27:24];
            return int'(nib);
        end
    endfunction

    // Looks the address up, refreshes a hit and then ages the cache if a sweep is due.
    function automatic int probe_and_age(input logic [31:0] a);
        int base;
        int hit;
        int w;
        int s;
        begin
            base = bucket_index(a) * WAY_COUNT;
            hit = -1;
            for (w = 0; w < WAY_COUNT && hit < 0; w++)
            begin
                if (ent_valid[base + w] && ent_addr[base + w] == a)
                begin
                    ent_stamp[base + w] = now_ticks;
                    hit = base + w;
                end
            end
            if (now_ticks - last_sweep > sweep_period)
            begin
                for (s = 0; s < SLOT_COUNT; s++)
                begin
                    if (ent_valid[s] && now_ticks - ent_stamp[s] > entry_timeout)
                        ent_valid[s] = 1'b0;
                end
                last_sweep = now_ticks;
            end
            return hit;
        end
    endfunction

    function automatic mtu_result_t predict_result(input txn_t t);
        mtu_result_t r;
        int slot;
        int base;
        int w;
        logic [15:0] trimmed;
        begin
            r = '0;
            base = bucket_index(t.dest_addr) * WAY_COUNT;
            if (t.mode == MODE_TRANSMIT)
            begin
                slot = probe_and_age(t.dest_addr);
                r.cache_hit = (slot >= 0);
                r.path_mtu = (slot >= 0) ? ent_mtu[slot] : t.route_mtu;
                r.dont_fragment = (r.path_mtu > DF_LIMIT);
                r.too_big = r.dont_fragment && (t.payload_len > r.path_mtu);
            end
            else if (t.mode == MODE_REPORT && t.icmp_type == ICMP_TYPE_UNREACH
                     && t.icmp_code == ICMP_CODE_FRAG)
            begin
                trimmed = (t.reported_mtu >= IPV4_HDR_LEN) ? t.reported_mtu - IPV4_HDR_LEN : 16'd0;
                r.path_mtu = trimmed;
                slot = probe_and_age(t.dest_addr);
                if (slot >= 0)
                begin
                    r.cache_hit = 1'b1;
                    ent_mtu[slot] = trimmed;
                    r.report_status = STATUS_UPDATED;
                end
                else
                begin
                    r.report_status = STATUS_DROPPED;
                    for (w = 0; w < WAY_COUNT; w++)
                    begin
                        if (!ent_valid[base + w])
                        begin
                            ent_valid[base + w] = 1'b1;
                            ent_addr[base + w] = t.dest_addr;
                            ent_mtu[base + w] = trimmed;
                            ent_stamp[base + w] = now_ticks;
                            r.report_status = STATUS_INSERTED;
                            break;
                        end
                    end
                end
            end
            else if (t.mode == MODE_TICK)
            begin
                now_ticks = now_ticks + 32'd1;
            end
            return r;
        end
    endfunction

    function automatic stim_row_t stim_row(input logic [1:0] m, input logic [31:0] a,
                                           input logic [7:0] ty, input logic [7:0] co,
                                           input logic [15:0] rep, input logic [15:0] rmtu,
                                           input logic [15:0] plen, input logic known,
                                           input logic hit, input logic [15:0] mtu,
                                           input logic big, input logic df,
                                           input logic [1:0] status);
        stim_row_t row;
        begin
            row.txn = '{m, a, ty, co, rep, rmtu, plen};
            row.known = known;
            row.want = '{hit, mtu, big, df, status};
            return row;
        end
    endfunction

    function automatic txn_t random_txn();
        txn_t t;
        int pick;
        begin
            pick = $urandom_range(99);
            t.dest_addr = ($urandom_range(99) < 85) ? addr_pool[$urandom_range(POOL_SIZE - 1)]
                                                    : $urandom;
            t.icmp_type = 8'($urandom);
            t.icmp_code = 8'($urandom);
            t.reported_mtu = 16'($urandom);
            t.route_mtu = 16'($urandom);
            t.payload_len = 16'($urandom);
            if (pick < 35)
            begin
                t.mode = MODE_TRANSMIT;
            end
            else if (pick < 67)
            begin
                t.mode = MODE_REPORT;
                if ($urandom_range(99) < 85)
                begin
                    t.icmp_type = ICMP_TYPE_UNREACH;
                    t.icmp_code = ICMP_CODE_FRAG;
                end
                if ($urandom_range(9) == 0)
                    t.reported_mtu = 16'($urandom_range(25));
            end
            else if (pick < 95)
            begin
                t.mode = MODE_TICK;
            end
            else
            begin
                t.mode = MODE_NONE;
            end
            return t;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            if (mismatch_count < 50)
                $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
            mismatch_count++;
        end
    endtask

    // Offers one transaction and records its expected result once it is accepted.
    task automatic send_txn(input txn_t t, input logic known, input mtu_result_t typed);
        mtu_result_t r;
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
            item_valid <= 1'b1;
            mode <= t.mode;
            dest_addr <= t.dest_addr;
            icmp_type <= t.icmp_type;
            icmp_code <= t.icmp_code;
            reported_mtu <= t.reported_mtu;
            route_mtu <= t.route_mtu;
            payload_len <= t.payload_len;
            @(posedge clk);
            while (item_stall)
                @(posedge clk);
            r = predict_result(t);
            pending_results.push_back(known ? typed : r);
        end
    endtask

    task automatic write_cfg(input logic [0:0] idx, input logic [31:0] value);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            if (idx == CFG_SWEEP_PERIOD)
                sweep_period = value;
            else
                entry_timeout = value;
        end
    endtask

    task automatic wait_drained();
        begin
            while (pending_results.size() != 0)
                @(posedge clk);
        end
    endtask

    // Result side: random stalls, or one long hold-off when asked for.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                result_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        mtu_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no transaction pending", path_mtu, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (cache_hit !== want.cache_hit)
                    report_mismatch("cache_hit", cache_hit, want.cache_hit);
                if (path_mtu !== want.path_mtu)
                    report_mismatch("path_mtu", path_mtu, want.path_mtu);
                if (too_big !== want.too_big)
                    report_mismatch("too_big", too_big, want.too_big);
                if (dont_fragment !== want.dont_fragment)
                    report_mismatch("dont_fragment", dont_fragment, want.dont_fragment);
                if (report_status !== want.report_status)
                    report_mismatch("report_status", report_status, want.report_status);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        txn_t t;
        int i;
        int phase;
        int active;
        logic [31:0] a;

        for (i = 0; i < SLOT_COUNT; i++)
        begin
            ent_valid[i] = 1'b0;
            ent_addr[i] = '0;
            ent_mtu[i] = '0;
            ent_stamp[i] = '0;
        end
        now_ticks = '0;
        last_sweep = '0;
        sweep_period = SWEEP_PERIOD_RESET;
        entry_timeout = ENTRY_TIMEOUT_RESET;

        // Six addresses per bucket in four buckets, so those buckets overflow.
        for (i = 0; i < POOL_SIZE; i++)
        begin
            a = $urandom;
            a[3:0] = 4'((i % 4) * 5) ^ a[11:8] ^ a[19:16] ^ a[27:24];
            addr_pool[i] = a;
        end

        // Field extremes and the DF threshold on a cold cache.
        directed_rows.push_back(stim_row(MODE_TRANSMIT, 32'h0, 8'h0, 8'h0, 16'h0, 16'd1500,
                                         16'd1600, 1, 0, 16'd1500, 1, 1, STATUS_IGNORED));
        directed_rows.push_back(stim_row(MODE_TRANSMIT, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF,
                                         16'd576, 16'hFFFF, 1, 0, 16'd576, 0, 0, STATUS_IGNORED));
        directed_rows.push_back(stim_row(MODE_TRANSMIT, 32'h0, 8'h0, 8'h0, 16'h0, 16'd577,
                                         16'd577, 1, 0, 16'd577, 0, 1, STATUS_IGNORED));
        directed_rows.push_back(stim_row(MODE_TRANSMIT, 32'hA5A5_A5A5, 8'h0, 8'h0, 16'h0,
                                         16'hFFFF, 16'hFFFF, 1, 0, 16'hFFFF, 0, 1,
                                         STATUS_IGNORED));
        directed_rows.push_back(stim_row(MODE_TRANSMIT, 32'h5A5A_5A5A, 8'h0, 8'h0, 16'h0,
                                         16'h0, 16'h0, 1, 0, 16'h0, 0, 0, STATUS_IGNORED));
        // Reported MTU below, at and far above the IPv4 header length.
        directed_rows.push_back(stim_row(MODE_REPORT, 32'h0, ICMP_TYPE_UNREACH, ICMP_CODE_FRAG,
                                         16'd19, 16'h0, 16'h0, 1, 0, 16'd0, 0, 0,
                                         STATUS_INSERTED));
        directed_rows.push_back(stim_row(MODE_REPORT, 32'h0, ICMP_TYPE_UNREACH, ICMP_CODE_FRAG,
                                         16'd20, 16'h0, 16'h0, 1, 1, 16'd0, 0, 0,
                                         STATUS_UPDATED));
        directed_rows.push_back(stim_row(MODE_REPORT, 32'h0, ICMP_TYPE_UNREACH, ICMP_CODE_FRAG,
                                         16'hFFFF, 16'h0, 16'h0, 1, 1, 16'd65515, 0, 0,
                                         STATUS_UPDATED));
        directed_rows.push_back(stim_row(MODE_TRANSMIT, 32'h0, 8'h0, 8'h0, 16'h0, 16'd100,
                                         16'hFFFF, 1, 1, 16'd65515, 1, 1, STATUS_IGNORED));
        // Reports of any other type or code are ignored.
        directed_rows.push_back(stim_row(MODE_REPORT, 32'h0, ICMP_TYPE_UNREACH, 8'd3,
                                         16'd1500, 16'h0, 16'h0, 1, 0, 16'd0, 0, 0,
                                         STATUS_IGNORED));
        directed_rows.push_back(stim_row(MODE_REPORT, 32'h0, 8'd4, ICMP_CODE_FRAG,
                                         16'd1500, 16'h0, 16'h0, 1, 0, 16'd0, 0, 0,
                                         STATUS_IGNORED));
        directed_rows.push_back(stim_row(MODE_REPORT, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF,
                                         16'hFFFF, 16'hFFFF, 1, 0, 16'd0, 0, 0,
                                         STATUS_IGNORED));
        directed_rows.push_back(stim_row(MODE_REPORT, 32'h0, 8'h0, 8'h0, 16'h0, 16'h0, 16'h0,
                                         1, 0, 16'd0, 0, 0, STATUS_IGNORED));
        directed_rows.push_back(stim_row(MODE_TICK, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF,
                                         16'hFFFF, 16'hFFFF, 1, 0, 16'd0, 0, 0,
                                         STATUS_IGNORED));
        directed_rows.push_back(stim_row(MODE_NONE, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF,
                                         16'hFFFF, 16'hFFFF, 1, 0, 16'd0, 0, 0,
                                         STATUS_IGNORED));
        // Fill bucket zero, then overflow it.
        directed_rows.push_back(stim_row(MODE_REPORT, 32'h0000_0010, ICMP_TYPE_UNREACH,
                                         ICMP_CODE_FRAG, 16'd1500, 16'h0, 16'h0, 0, 0, 16'd0,
                                         0, 0, STATUS_IGNORED));
        directed_rows.push_back(stim_row(MODE_REPORT, 32'h0000_0020, ICMP_TYPE_UNREACH,
                                         ICMP_CODE_FRAG, 16'd1400, 16'h0, 16'h0, 0, 0, 16'd0,
                                         0, 0, STATUS_IGNORED));
        directed_rows.push_back(stim_row(MODE_REPORT, 32'hFF0F_F0F0, ICMP_TYPE_UNREACH,
                                         ICMP_CODE_FRAG, 16'd1500, 16'h0, 16'h0, 0, 0, 16'd0,
                                         0, 0, STATUS_IGNORED));
        directed_rows.push_back(stim_row(MODE_REPORT, 32'h1000_0030, ICMP_TYPE_UNREACH,
                                         ICMP_CODE_FRAG, 16'd9000, 16'h0, 16'h0, 1, 0,
                                         16'd8980, 0, 0, STATUS_DROPPED));
        directed_rows.push_back(stim_row(MODE_TRANSMIT, 32'h1000_0030, 8'h0, 8'h0, 16'h0,
                                         16'd1400, 16'd1401, 0, 0, 16'd0, 0, 0, STATUS_IGNORED));
        directed_rows.push_back(stim_row(MODE_TRANSMIT, 32'hFF0F_F0F0, 8'h0, 8'h0, 16'h0,
                                         16'h0, 16'd1481, 0, 0, 16'd0, 0, 0, STATUS_IGNORED));
        directed_rows.push_back(stim_row(MODE_TRANSMIT, 32'h0000_0020, 8'h0, 8'h0, 16'h0,
                                         16'h0, 16'd1380, 0, 0, 16'd0, 0, 0, STATUS_IGNORED));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 7;
        recv_idle_pct = 59;
        for (i = 0; i < directed_rows.size(); i++)
            send_txn(directed_rows[i].txn, directed_rows[i].known, directed_rows[i].want);

        for (phase = 0; phase < PHASES; phase++)
        begin
            // Registers change only with nothing in flight.
            item_valid <= 1'b0;
            wait_drained();
            write_cfg(CFG_SWEEP_PERIOD, phase_period[phase]);
            write_cfg(CFG_ENTRY_TIMEOUT, phase_timeout[phase]);
            if (phase < 2)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 59;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 59;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 1)
                hold_pending = 1'b1;
            active = 0;
            while (active < PHASE_ITEMS)
            begin
                t = random_txn();
                send_txn(t, 1'b0, '0);
                active++;
            end
        end

        item_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
